FILE: sv/tmpe_pkg.sv
// Shared widths, constants, register codes and pipeline sideband types.
package tmpe_pkg;

  localparam int unsigned LenW     = 20;
  localparam int unsigned PosW     = 21;
  localparam int unsigned SpdW     = 17;
  localparam int unsigned AccW     = 20;
  localparam int unsigned TimeW    = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam int unsigned VvW      = 2 * SpdW;
  localparam int unsigned AlW      = AccW + LenW;
  localparam int unsigned AvW      = AccW + SpdW;
  localparam int unsigned NumTW    = 49;
  localparam int unsigned DenTW    = AvW + 1;
  localparam int unsigned QtW      = 25;
  localparam int unsigned TRemW    = NumTW - QtW;
  localparam int unsigned NumRW    = 38;
  localparam int unsigned RootTW   = NumRW / 2;
  localparam int unsigned MW       = VvW;
  localparam int unsigned SpdRootW = MW / 2;

  localparam int unsigned Latency  = 3 + NumRW + QtW + RootTW + SpdRootW + 1;

  localparam logic [SpdW-1:0]  SpeedRst  = 17'd5000;
  localparam logic [AccW-1:0]  AccelRst  = 20'd10000;
  localparam logic [TimeW-1:0] TimeMax   = '1;
  localparam logic [NumTW-1:0] TrapScale = 49'd200;
  localparam logic [NumRW-1:0] TriScale  = 38'd160000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxSpeed = 2'd0,
    CfgMaxAccel = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [TRemW-1:0] trem;
    logic [QtW-1:0]   tlow;
    logic [DenTW-1:0] tden;
    logic [MW-1:0]    m;
    logic             triangle;
    logic             zero;
  } side1_t;

  typedef struct packed {
    logic [NumRW-1:0] triq;
    logic [MW-1:0]    m;
    logic             triangle;
    logic             zero;
    logic             ovf;
  } side2_t;

  typedef struct packed {
    logic [QtW-1:0] trapq;
    logic           ovf;
    logic [MW-1:0]  m;
    logic           triangle;
    logic           zero;
  } side3_t;

  typedef struct packed {
    logic [QtW-1:0]    trapq;
    logic              ovf;
    logic [RootTW-1:0] troot;
    logic              triangle;
    logic              zero;
  } side4_t;

endpackage

FILE: sv/tmpe_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tmpe_div #(
  parameter int unsigned DW = 20,
  parameter int unsigned QW = 38,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [PW-1:0] side_o
);

  logic [QW:0]   vld_s;
  logic [DW-1:0] rem_s  [QW+1];
  logic [QW-1:0] nq_s   [QW+1];
  logic [DW-1:0] den_s  [QW+1];
  logic [PW-1:0] side_s [QW+1];

  assign vld_s[0]  = valid_i;
  assign rem_s[0]  = rem_i;
  assign nq_s[0]   = num_i;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   cat;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [QW-1:0] nq_d;
    logic          vld_q;
    logic [DW-1:0] rem_q;
    logic [QW-1:0] nq_q;
    logic [DW-1:0] den_q;
    logic [PW-1:0] side_q;

    assign cat   = {rem_s[k], nq_s[k][QW-1]};
    assign diff  = cat - {1'b0, den_s[k]};
    assign ge    = cat >= {1'b0, den_s[k]};
    assign rem_d = ge ? diff[DW-1:0] : cat[DW-1:0];
    assign nq_d  = {nq_s[k][QW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      den_q  <= den_s[k];
      side_q <= side_s[k];
    end

    assign vld_s[k+1]  = vld_q;
    assign rem_s[k+1]  = rem_q;
    assign nq_s[k+1]   = nq_q;
    assign den_s[k+1]  = den_q;
    assign side_s[k+1] = side_q;
  end

  assign valid_o = vld_s[QW];
  assign quo_o   = nq_s[QW];
  assign side_o  = side_s[QW];

endmodule

FILE: sv/tmpe_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module tmpe_sqrt #(
  parameter int unsigned RW = 17,
  parameter int unsigned PW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-1:0] x_i,
  input  logic [PW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [PW-1:0]   side_o
);

  logic [RW:0]     vld_s;
  logic [RW:0]     rem_s  [RW+1];
  logic [2*RW-1:0] xs_s   [RW+1];
  logic [RW-1:0]   root_s [RW+1];
  logic [PW-1:0]   side_s [RW+1];

  assign vld_s[0]  = valid_i;
  assign rem_s[0]  = '0;
  assign xs_s[0]   = x_i;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0]   cat;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;
    logic [RW:0]     rem_d;
    logic [2*RW-1:0] xs_d;
    logic [RW-1:0]   root_d;
    logic            vld_q;
    logic [RW:0]     rem_q;
    logic [2*RW-1:0] xs_q;
    logic [RW-1:0]   root_q;
    logic [PW-1:0]   side_q;

    assign cat    = {rem_s[k], xs_s[k][2*RW-1 -: 2]};
    assign trial  = {1'b0, root_s[k], 2'b01};
    assign diff   = cat - trial;
    assign ge     = cat >= trial;
    assign rem_d  = ge ? diff[RW:0] : cat[RW:0];
    assign xs_d   = {xs_s[k][2*RW-3:0], 2'b00};
    assign root_d = {root_s[k][RW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= rem_d;
      xs_q   <= xs_d;
      root_q <= root_d;
      side_q <= side_s[k];
    end

    assign vld_s[k+1]  = vld_q;
    assign rem_s[k+1]  = rem_q;
    assign xs_s[k+1]   = xs_q;
    assign root_s[k+1] = root_q;
    assign side_s[k+1] = side_q;
  end

  assign valid_o = vld_s[RW];
  assign root_o  = root_s[RW];
  assign side_o  = side_s[RW];

endmodule

FILE: sv/tmpe_front.sv
// Front stages: clamp position, form products, dividends and ramp limit.
module tmpe_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [tmpe_pkg::LenW-1:0]     move_length_i,
  input  logic [tmpe_pkg::PosW-1:0]     position_i,
  input  logic [tmpe_pkg::SpdW-1:0]     max_speed_i,
  input  logic [tmpe_pkg::AccW-1:0]     max_accel_i,
  output logic                          valid_o,
  output logic [tmpe_pkg::NumRW-1:0]    numr_o,
  output logic [tmpe_pkg::AccW-1:0]     accel_o,
  output tmpe_pkg::side1_t              side_o
);
  import tmpe_pkg::*;

  logic [LenW-1:0] p;
  logic [LenW-1:0] s_d;
  logic [SpdW-1:0] v_d;
  logic [AccW-1:0] a_d;

  logic            vld1_q, vld2_q, vld3_q;
  logic [SpdW-1:0] v1_q;
  logic [AccW-1:0] a1_q, a2_q, a3_q;
  logic [LenW-1:0] l1_q, s1_q, ls1_q, l2_q;
  logic [VvW-1:0]  vv2_q;
  logic [AlW-1:0]  al2_q, r1_q, r2_q;
  logic [AvW-1:0]  av2_q;
  logic            zero2_q;

  logic [AlW:0]    sum;
  logic [NumTW-1:0] numt;
  logic [AlW-1:0]  mn;
  logic [AlW:0]    mn2;
  logic [MW-1:0]   m;
  logic            triangle;
  logic [NumRW-1:0] numr_q;
  side1_t          side_q;
  side1_t          side_d;

  assign p   = position_i[LenW-1:0];
  assign s_d = position_i[PosW-1] ? '0 : ((p > move_length_i) ? move_length_i : p);
  assign v_d = (max_speed_i == '0) ? SpdW'(1) : max_speed_i;
  assign a_d = (max_accel_i == '0) ? AccW'(1) : max_accel_i;

  assign triangle = AlW'(vv2_q) > al2_q;
  assign sum      = (AlW+1)'(vv2_q) + (AlW+1)'(al2_q);
  assign numt     = NumTW'(sum) * TrapScale + NumTW'(av2_q);
  assign mn       = (r1_q < r2_q) ? r1_q : r2_q;
  assign mn2      = {mn, 1'b0};
  assign m        = ((AlW+1)'(vv2_q) < mn2) ? vv2_q : mn2[MW-1:0];

  always_comb begin
    side_d.trem     = numt[NumTW-1:QtW];
    side_d.tlow     = numt[QtW-1:0];
    side_d.tden     = {av2_q, 1'b0};
    side_d.m        = m;
    side_d.triangle = triangle;
    side_d.zero     = zero2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    v1_q    <= v_d;
    a1_q    <= a_d;
    l1_q    <= move_length_i;
    s1_q    <= s_d;
    ls1_q   <= move_length_i - s_d;
    vv2_q   <= VvW'(v1_q) * VvW'(v1_q);
    al2_q   <= AlW'(a1_q) * AlW'(l1_q);
    av2_q   <= AvW'(a1_q) * AvW'(v1_q);
    r1_q    <= AlW'(a1_q) * AlW'(s1_q);
    r2_q    <= AlW'(a1_q) * AlW'(ls1_q);
    l2_q    <= l1_q;
    a2_q    <= a1_q;
    zero2_q <= (l1_q == '0);
    numr_q  <= NumRW'(l2_q) * TriScale;
    a3_q    <= a2_q;
    side_q  <= side_d;
  end

  assign valid_o = vld3_q;
  assign numr_o  = numr_q;
  assign accel_o = a3_q;
  assign side_o  = side_q;

endmodule

FILE: sv/trapezoid_motion_profile_eval.sv
// Top level: trapezoidal velocity profile evaluator with config registers.
//
// Command channel: present move_length_i and position_i with start_i high;
// the transaction is taken on any edge where start_i is high and busy_o is
// low. busy_o stays low, so a new transaction may enter every cycle.
// Result channel: done_o pulses for one cycle with move_time_o, speed_here_o
// and is_triangle_o valid. The receiver cannot stall; results are never held.
// From the accepting edge to done_o, a transaction passes through 3 front
// stages (clamp, multiplies, dividend forming), a 38-stage divider for
// the triangle time, a 25-stage divider for the trapezoid time, 19- and
// 17-stage square root pipelines and one output register. Throughput is
// one transaction per cycle.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 max speed,
// 1 max acceleration) and cfg_data_i; cfg_ready_o is always high and
// unknown indexes are dropped. Write config only while the pipeline is empty.
// Reset clears the pipeline and loads max speed 5000 and max accel 10000.
module trapezoid_motion_profile_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tmpe_pkg::LenW-1:0]     move_length_i,
  input  logic [tmpe_pkg::PosW-1:0]     position_i,
  output logic                          done_o,
  output logic [tmpe_pkg::TimeW-1:0]    move_time_o,
  output logic [tmpe_pkg::SpdW-1:0]     speed_here_o,
  output logic                          is_triangle_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmpe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tmpe_pkg::CfgDataW-1:0] cfg_data_i
);
  import tmpe_pkg::*;

  logic [SpdW-1:0] speed_q;
  logic [AccW-1:0] accel_q;

  logic             f_vld;
  logic [NumRW-1:0] f_numr;
  logic [AccW-1:0]  f_accel;
  side1_t           f_side;

  logic                     d1_vld;
  logic [NumRW-1:0]         d1_quo;
  logic [$bits(side1_t)-1:0] d1_vec;
  side1_t                   s1;
  side2_t                   s2_in;

  logic                     d2_vld;
  logic [QtW-1:0]           d2_quo;
  logic [$bits(side2_t)-1:0] d2_vec;
  side2_t                   s2;
  side3_t                   s3_in;

  logic                     q1_vld;
  logic [RootTW-1:0]        q1_root;
  logic [$bits(side3_t)-1:0] q1_vec;
  side3_t                   s3;
  side4_t                   s4_in;

  logic                     q2_vld;
  logic [SpdRootW-1:0]      q2_root;
  logic [$bits(side4_t)-1:0] q2_vec;
  side4_t                   s4;

  logic [RootTW:0]  tri_sum;
  logic [TimeW-1:0] move_time_d;
  logic             done_q;
  logic [TimeW-1:0] move_time_q;
  logic [SpdW-1:0]  speed_here_q;
  logic             is_triangle_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SpeedRst;
      accel_q <= AccelRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMaxSpeed: speed_q <= cfg_data_i[SpdW-1:0];
        CfgMaxAccel: accel_q <= cfg_data_i[AccW-1:0];
        default: ;
      endcase
    end
  end

  tmpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i && !busy_o),
    .move_length_i (move_length_i),
    .position_i    (position_i),
    .max_speed_i   (speed_q),
    .max_accel_i   (accel_q),
    .valid_o       (f_vld),
    .numr_o        (f_numr),
    .accel_o       (f_accel),
    .side_o        (f_side)
  );

  tmpe_div #(.DW(AccW), .QW(NumRW), .PW($bits(side1_t))) u_div_tri (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld),
    .rem_i   ('0),
    .num_i   (f_numr),
    .den_i   (f_accel),
    .side_i  (f_side),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_vec)
  );

  assign s1 = d1_vec;

  always_comb begin
    s2_in.triq     = d1_quo;
    s2_in.m        = s1.m;
    s2_in.triangle = s1.triangle;
    s2_in.zero     = s1.zero;
    s2_in.ovf      = DenTW'(s1.trem) >= s1.tden;
  end

  tmpe_div #(.DW(DenTW), .QW(QtW), .PW($bits(side2_t))) u_div_trap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d1_vld),
    .rem_i   (DenTW'(s1.trem)),
    .num_i   (s1.tlow),
    .den_i   (s1.tden),
    .side_i  (s2_in),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_vec)
  );

  assign s2 = d2_vec;

  always_comb begin
    s3_in.trapq    = d2_quo;
    s3_in.ovf      = s2.ovf;
    s3_in.m        = s2.m;
    s3_in.triangle = s2.triangle;
    s3_in.zero     = s2.zero;
  end

  tmpe_sqrt #(.RW(RootTW), .PW($bits(side3_t))) u_sqrt_tri (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d2_vld),
    .x_i     (s2.triq),
    .side_i  (s3_in),
    .valid_o (q1_vld),
    .root_o  (q1_root),
    .side_o  (q1_vec)
  );

  assign s3 = q1_vec;

  always_comb begin
    s4_in.trapq    = s3.trapq;
    s4_in.ovf      = s3.ovf;
    s4_in.troot    = q1_root;
    s4_in.triangle = s3.triangle;
    s4_in.zero     = s3.zero;
  end

  tmpe_sqrt #(.RW(SpdRootW), .PW($bits(side4_t))) u_sqrt_spd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q1_vld),
    .x_i     (s3.m),
    .side_i  (s4_in),
    .valid_o (q2_vld),
    .root_o  (q2_root),
    .side_o  (q2_vec)
  );

  assign s4      = q2_vec;
  assign tri_sum = (RootTW+1)'(s4.troot) + (RootTW+1)'(1);

  always_comb begin
    if (s4.zero) begin
      move_time_d = '0;
    end else if (s4.triangle) begin
      move_time_d = TimeW'(tri_sum[RootTW:1]);
    end else if (s4.ovf || s4.trapq[QtW-1]) begin
      move_time_d = TimeMax;
    end else begin
      move_time_d = s4.trapq[TimeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= q2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    move_time_q   <= move_time_d;
    speed_here_q  <= s4.zero ? '0 : SpdW'(q2_root);
    is_triangle_q <= s4.triangle && !s4.zero;
  end

  assign done_o        = done_q;
  assign move_time_o   = move_time_q;
  assign speed_here_o  = speed_here_q;
  assign is_triangle_o = is_triangle_q;

endmodule

FILE: sv/tmpe_chk.sv
// Port-level checker for the profile evaluator, bound to the top level.
module tmpe_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [tmpe_pkg::TimeW-1:0] move_time_o,
  input logic                       is_triangle_o
);
  import tmpe_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o raised");

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without matching transaction");

  a_tri_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_triangle_o) |-> (move_time_o[TimeW-1:18] == '0))
    else $error("triangle time out of range");

endmodule

bind trapezoid_motion_profile_eval tmpe_chk u_tmpe_chk (.*);
